@@ rtl/direction_codebook_quantizer_defines.svh @@
// assertion macros included by the quantizer rtl
`ifndef DIRECTION_CODEBOOK_QUANTIZER_DEFINES_SVH
`define DIRECTION_CODEBOOK_QUANTIZER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DCQ_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define DCQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/dcq_pkg.sv @@
package dcq_pkg;

  localparam int unsigned DIR_W        = 16;
  localparam int unsigned IDX_W        = 8;
  localparam int unsigned DOT_W        = 32;
  localparam int unsigned ROM_ENTRIES  = 162;
  localparam int unsigned NUM_DIRS_DEF = 162;
  localparam int unsigned AXIS_W       = 2;

  localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_Y = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

  // one dot product in flight along the cell row
  typedef struct packed {
    logic                    last;
    logic [IDX_W-1:0]        idx;
    logic signed [DOT_W-1:0] psum;
  } beat_t;

  // unit normal components in q1.14
  localparam logic signed [DIR_W-1:0] K148  = 16'sd2419;
  localparam logic signed [DIR_W-1:0] K162  = 16'sd2662;
  localparam logic signed [DIR_W-1:0] K239  = 16'sd3913;
  localparam logic signed [DIR_W-1:0] K263  = 16'sd4307;
  localparam logic signed [DIR_W-1:0] K295  = 16'sd4837;
  localparam logic signed [DIR_W-1:0] K309  = 16'sd5063;
  localparam logic signed [DIR_W-1:0] K425  = 16'sd6969;
  localparam logic signed [DIR_W-1:0] K443  = 16'sd7256;
  localparam logic signed [DIR_W-1:0] K500  = 16'sd8192;
  localparam logic signed [DIR_W-1:0] K526  = 16'sd8614;
  localparam logic signed [DIR_W-1:0] K588  = 16'sd9630;
  localparam logic signed [DIR_W-1:0] K682  = 16'sd11169;
  localparam logic signed [DIR_W-1:0] K688  = 16'sd11275;
  localparam logic signed [DIR_W-1:0] K717  = 16'sd11740;
  localparam logic signed [DIR_W-1:0] K809  = 16'sd13255;
  localparam logic signed [DIR_W-1:0] K851  = 16'sd13937;
  localparam logic signed [DIR_W-1:0] K864  = 16'sd14159;
  localparam logic signed [DIR_W-1:0] K951  = 16'sd15582;
  localparam logic signed [DIR_W-1:0] K955  = 16'sd15654;
  localparam logic signed [DIR_W-1:0] K1    = 16'sd16384;
  localparam logic signed [DIR_W-1:0] KZ    = 16'sd0;

  localparam logic signed [DIR_W-1:0] NORMAL_ROM [ROM_ENTRIES][3] = '{
    '{-K526,KZ,K851},'{-K443,K239,K864},'{-K295,KZ,K955},
    '{-K309,K500,K809},'{-K162,K263,K951},'{KZ,KZ,K1},
    '{KZ,K851,K526},'{-K148,K717,K682},'{K148,K717,K682},
    '{KZ,K526,K851},'{K309,K500,K809},'{K526,KZ,K851},
    '{K295,KZ,K955},'{K443,K239,K864},'{K162,K263,K951},
    '{-K682,K148,K717},'{-K809,K309,K500},'{-K588,K425,K688},
    '{-K851,K526,KZ},'{-K864,K443,K239},'{-K717,K682,K148},
    '{-K688,K588,K425},'{-K500,K809,K309},'{-K239,K864,K443},
    '{-K425,K688,K588},'{-K717,K682,-K148},'{-K500,K809,-K309},
    '{-K526,K851,KZ},'{KZ,K851,-K526},'{-K239,K864,-K443},
    '{KZ,K955,-K295},'{-K263,K951,-K162},'{KZ,K1,KZ},
    '{KZ,K955,K295},'{-K263,K951,K162},'{K239,K864,K443},
    '{K263,K951,K162},'{K500,K809,K309},'{K239,K864,-K443},
    '{K263,K951,-K162},'{K500,K809,-K309},'{K851,K526,KZ},
    '{K717,K682,K148},'{K717,K682,-K148},'{K526,K851,KZ},
    '{K425,K688,K588},'{K864,K443,K239},'{K688,K588,K425},
    '{K809,K309,K500},'{K682,K148,K717},'{K588,K425,K688},
    '{K955,K295,KZ},'{K1,KZ,KZ},'{K951,K162,K263},
    '{K851,-K526,KZ},'{K955,-K295,KZ},'{K864,-K443,K239},
    '{K951,-K162,K263},'{K809,-K309,K500},'{K682,-K148,K717},
    '{K851,KZ,K526},'{K864,K443,-K239},'{K809,K309,-K500},
    '{K951,K162,-K263},'{K526,KZ,-K851},'{K682,K148,-K717},
    '{K682,-K148,-K717},'{K851,KZ,-K526},'{K809,-K309,-K500},
    '{K864,-K443,-K239},'{K951,-K162,-K263},'{K148,K717,-K682},
    '{K309,K500,-K809},'{K425,K688,-K588},'{K443,K239,-K864},
    '{K588,K425,-K688},'{K688,K588,-K425},'{-K148,K717,-K682},
    '{-K309,K500,-K809},'{KZ,K526,-K851},'{-K526,KZ,-K851},
    '{-K443,K239,-K864},'{-K295,KZ,-K955},'{-K162,K263,-K951},
    '{KZ,KZ,-K1},'{K295,KZ,-K955},'{K162,K263,-K951},
    '{-K443,-K239,-K864},'{-K309,-K500,-K809},'{-K162,-K263,-K951},
    '{KZ,-K851,-K526},'{-K148,-K717,-K682},'{K148,-K717,-K682},
    '{KZ,-K526,-K851},'{K309,-K500,-K809},'{K443,-K239,-K864},
    '{K162,-K263,-K951},'{K239,-K864,-K443},'{K500,-K809,-K309},
    '{K425,-K688,-K588},'{K717,-K682,-K148},'{K688,-K588,-K425},
    '{K588,-K425,-K688},'{KZ,-K955,-K295},'{KZ,-K1,KZ},
    '{K263,-K951,-K162},'{KZ,-K851,K526},'{KZ,-K955,K295},
    '{K239,-K864,K443},'{K263,-K951,K162},'{K500,-K809,K309},
    '{K717,-K682,K148},'{K526,-K851,KZ},'{-K239,-K864,-K443},
    '{-K500,-K809,-K309},'{-K263,-K951,-K162},'{-K851,-K526,KZ},
    '{-K717,-K682,-K148},'{-K717,-K682,K148},'{-K526,-K851,KZ},
    '{-K500,-K809,K309},'{-K239,-K864,K443},'{-K263,-K951,K162},
    '{-K864,-K443,K239},'{-K809,-K309,K500},'{-K688,-K588,K425},
    '{-K682,-K148,K717},'{-K443,-K239,K864},'{-K588,-K425,K688},
    '{-K309,-K500,K809},'{-K148,-K717,K682},'{-K425,-K688,K588},
    '{-K162,-K263,K951},'{K443,-K239,K864},'{K162,-K263,K951},
    '{K309,-K500,K809},'{K148,-K717,K682},'{KZ,-K526,K851},
    '{K425,-K688,K588},'{K588,-K425,K688},'{K688,-K588,K425},
    '{-K955,K295,KZ},'{-K951,K162,K263},'{-K1,KZ,KZ},
    '{-K851,KZ,K526},'{-K955,-K295,KZ},'{-K951,-K162,K263},
    '{-K864,K443,-K239},'{-K951,K162,-K263},'{-K809,K309,-K500},
    '{-K864,-K443,-K239},'{-K951,-K162,-K263},'{-K809,-K309,-K500},
    '{-K682,K148,-K717},'{-K682,-K148,-K717},'{-K851,KZ,-K526},
    '{-K688,K588,-K425},'{-K588,K425,-K688},'{-K425,K688,-K588},
    '{-K425,-K688,-K588},'{-K588,-K425,-K688},'{-K688,-K588,-K425}
  };

  // one component of one codebook normal, zero past the table
  function automatic logic signed [DIR_W-1:0] rom_coef(input logic [IDX_W-1:0] idx,
                                                       input logic [AXIS_W-1:0] axis);
    logic signed [DIR_W-1:0] c;
    c = '0;
    if ((idx < IDX_W'(ROM_ENTRIES)) && (axis != 2'd3)) begin
      c = NORMAL_ROM[idx][axis];
    end
    return c;
  endfunction

endpackage

@@ rtl/dcq_cell.sv @@
// one axis of the dot product: table read, then multiply-accumulate
module dcq_cell #(
  parameter logic [dcq_pkg::AXIS_W-1:0] AXIS = dcq_pkg::AXIS_X
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               load,
  input  logic signed [dcq_pkg::DIR_W-1:0]   comp,
  input  logic                               beat_in_vld,
  input  dcq_pkg::beat_t                     beat_in,
  output logic                               beat_out_vld,
  output dcq_pkg::beat_t                     beat_out
);

  logic signed [dcq_pkg::DIR_W-1:0] comp_r;
  logic signed [dcq_pkg::DIR_W-1:0] coef_r;
  logic signed [dcq_pkg::DOT_W-1:0] prod;
  dcq_pkg::beat_t                   a_r;
  dcq_pkg::beat_t                   b_r;
  logic                             a_vld_r;
  logic                             b_vld_r;

  assign prod = comp_r * coef_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      a_vld_r <= beat_in_vld;
      b_vld_r <= a_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      comp_r <= comp;
    end
    a_r     <= beat_in;
    coef_r  <= dcq_pkg::rom_coef(beat_in.idx, AXIS);
    b_r.last <= a_r.last;
    b_r.idx  <= a_r.idx;
    b_r.psum <= a_r.psum + prod;
  end

  assign beat_out_vld = b_vld_r;
  assign beat_out     = b_r;

endmodule

@@ rtl/direction_codebook_quantizer.sv @@
// channel | beat fields                          | handshake
// in      | in_dir_x, in_dir_y, in_dir_z (s16)   | in_valid / in_stall
// out     | out_normal_index (u8)                | out_valid / out_stall
//
// one input beat is accepted, then min(NUM_DIRS, 162) codebook entries leave
// the index counter, one per cycle; the three-cell row adds six stages of
// latency, followed by the final compare and the output load
// rst_n is synchronous; it clears the state machine and all valid bits
// in_stall is high from accept until the result is loaded into the output
// register; a waiting result does not block the next accept, only the load
`include "direction_codebook_quantizer_defines.svh"

module direction_codebook_quantizer #(
  parameter int unsigned NUM_DIRS = dcq_pkg::NUM_DIRS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic signed [dcq_pkg::DIR_W-1:0] in_dir_x,
  input  logic signed [dcq_pkg::DIR_W-1:0] in_dir_y,
  input  logic signed [dcq_pkg::DIR_W-1:0] in_dir_z,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [dcq_pkg::IDX_W-1:0]        out_normal_index
);

  // entries past the table never win, so the sweep stops at its end
  localparam int unsigned SEARCH   = (NUM_DIRS < dcq_pkg::ROM_ENTRIES) ? NUM_DIRS
                                                                     : dcq_pkg::ROM_ENTRIES;
  localparam logic [dcq_pkg::IDX_W-1:0] LAST_IDX = dcq_pkg::IDX_W'(SEARCH - 1);
  localparam int unsigned NCELL = 3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_DRAIN,
    S_HOLD
  } state_t;

  state_t                           state_r;
  logic [dcq_pkg::IDX_W-1:0]        cnt_r;
  logic signed [dcq_pkg::DOT_W-1:0] best_dot_r;
  logic [dcq_pkg::IDX_W-1:0]        best_idx_r;
  logic                             out_valid_r;
  logic [dcq_pkg::IDX_W-1:0]        out_normal_index_r;
  logic                             load;
  dcq_pkg::beat_t                   issue_r;
  logic                             issue_vld_r;

  // beats along the cell row; slot 0 is the index issue register
  dcq_pkg::beat_t                   chain    [NCELL+1];
  logic                             chain_vld[NCELL+1];
  logic signed [dcq_pkg::DIR_W-1:0] comps    [NCELL];

  assign load         = in_valid && !in_stall;
  assign in_stall     = (state_r != S_IDLE);
  assign comps[0]     = in_dir_x;
  assign comps[1]     = in_dir_y;
  assign comps[2]     = in_dir_z;
  assign chain[0]     = issue_r;
  assign chain_vld[0] = issue_vld_r;

  // x cell, y cell, z cell: each adds its component product to the running sum
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    dcq_cell #(
      .AXIS (dcq_pkg::AXIS_W'(g))
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .load         (load),
      .comp         (comps[g]),
      .beat_in_vld  (chain_vld[g]),
      .beat_in      (chain[g]),
      .beat_out_vld (chain_vld[g+1]),
      .beat_out     (chain[g+1])
    );
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      issue_vld_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      issue_vld_r  <= 1'b0;
      issue_r.last <= 1'b0;
      issue_r.idx  <= cnt_r;
      issue_r.psum <= '0;
      // result taken by the far side
      if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            cnt_r      <= '0;
            best_dot_r <= '0;
            best_idx_r <= '0;
            state_r    <= S_ISSUE;
          end
        end
        S_ISSUE: begin
          // one codebook entry into the row per cycle
          issue_vld_r  <= 1'b1;
          issue_r.last <= (cnt_r == LAST_IDX);
          cnt_r        <= cnt_r + 1'b1;
          if (cnt_r == LAST_IDX) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (chain_vld[NCELL] && chain[NCELL].last) begin
            state_r <= S_HOLD;
          end
        end
        S_HOLD: begin
          // load once the output register is free or being emptied
          if (!out_valid_r || !out_stall) begin
            out_valid_r        <= 1'b1;
            out_normal_index_r <= best_idx_r;
            state_r            <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
      // strict compare against a running best that starts at zero,
      // so the lowest index wins a tie and no positive dot gives index 0
      if (chain_vld[NCELL] && (chain[NCELL].psum > best_dot_r)) begin
        best_dot_r <= chain[NCELL].psum;
        best_idx_r <= chain[NCELL].idx;
      end
    end
  end

  assign out_valid        = out_valid_r;
  assign out_normal_index = out_normal_index_r;

  // the last entry leaves the row only while the sweep drains
  `DCQ_ASSERT_NOW(a_last_in_drain, clk, rst_n,
    chain_vld[NCELL] && chain[NCELL].last, state_r == S_DRAIN, "last beat outside drain")

  // nothing moves through the row while idle
  `DCQ_ASSERT_NOW(a_row_empty_idle, clk, rst_n,
    state_r == S_IDLE, !chain_vld[NCELL] && !chain_vld[0], "row busy while idle")

  // a presented result always names a searched entry
  `DCQ_ASSERT_NOW(a_index_range, clk, rst_n,
    out_valid_r, out_normal_index_r <= LAST_IDX, "result index out of range")

  // a result load leaves the block idle with a valid output
  `DCQ_ASSERT_NEXT(a_hold_load, clk, rst_n,
    state_r == S_HOLD && (!out_valid_r || !out_stall),
    out_valid_r && state_r == S_IDLE, "result load missed")

endmodule
